[hdl/lras_pkg.sv]
package lras_pkg;

	// Request codes
	localparam logic [1:0] REQ_SET_LEVEL  = 2'd0;
	localparam logic [1:0] REQ_SET_MUTED  = 2'd1;
	localparam logic [1:0] REQ_MUTE       = 2'd2;
	localparam logic [1:0] REQ_UNMUTE     = 2'd3;

	// Send modes
	localparam logic MODE_NORMAL    = 1'b0;
	localparam logic MODE_POWERSAVE = 1'b1;
	localparam logic MODE_RESET     = MODE_POWERSAVE;

	// Relay pair codes and frame wiring
	localparam logic [1:0]  PAIR_PASS    = 2'b10;
	localparam logic [1:0]  PAIR_ATTEN   = 2'b01;
	localparam logic [11:0] HI_WIRE_MASK = 12'hFC0;
	localparam logic [11:0] LO_WIRE_MASK = 12'h03F;
	localparam int          UNMUTE_POS   = 8;
	localparam int          WIRED_BITS   = 6;

	typedef struct packed {
		logic [15:0] relay_word;
		logic        hold_after;
		logic        last;
	} frame_t;

	// Relay frame for the six wired level bits; frame bit 8 is the active-low mute line.
	function automatic logic [15:0] build_frame(
		input logic [WIRED_BITS-1:0] pass_bits,
		input logic [WIRED_BITS-1:0] atten_bits,
		input logic                  muted
	);
		logic [11:0] pairs;
		logic [11:0] hi;
		logic [11:0] lo;
		logic [15:0] word;
		pairs = '0;
		for (int b = 0; b < WIRED_BITS; b++) begin
			pairs[2*b+1] = pass_bits[b] & PAIR_PASS[1];
			pairs[2*b]   = atten_bits[b] & PAIR_ATTEN[0];
		end
		hi = pairs & HI_WIRE_MASK;
		lo = pairs & LO_WIRE_MASK;
		word = '0;
		word[14:9] = hi[11:6];
		word[6:1]  = lo[5:0];
		word[UNMUTE_POS] = ~muted;
		return word;
	endfunction

endpackage

[hdl/lras_front.sv]
module lras_front #(
	parameter int LEVEL_BITS = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [1:0]            req_type,
	input  logic [5:0]            level,
	input  logic                  mute_flag,
	input  logic                  send_mode_we,
	input  logic                  send_mode,
	input  logic                  q_full,
	output logic                  q_push,
	output logic [LEVEL_BITS+1:0] q_data
);
	import lras_pkg::*;

	logic [LEVEL_BITS-1:0] level_q;
	logic                  muted_q;
	logic                  mode_q;
	logic                  accept;
	logic                  redundant;
	logic [LEVEL_BITS+5:0] lv_ext;
	logic [LEVEL_BITS-1:0] lv;
	logic [LEVEL_BITS-1:0] next_level;
	logic                  next_muted;

	assign lv_ext = {{LEVEL_BITS{1'b0}}, level};
	assign lv     = lv_ext[LEVEL_BITS-1:0];
	assign accept = push & ~q_full;

	always_comb begin
		next_level = level_q;
		next_muted = muted_q;
		redundant  = 1'b0;
		unique case (req_type)
			REQ_SET_LEVEL: next_level = lv;
			REQ_SET_MUTED: begin
				next_level = lv;
				next_muted = mute_flag;
			end
			REQ_MUTE: begin
				redundant  = muted_q;
				next_muted = 1'b1;
			end
			REQ_UNMUTE: begin
				redundant  = ~muted_q;
				next_muted = 1'b0;
			end
			default: ;
		endcase
	end

	assign q_push = accept & ~redundant;
	assign q_data = {next_level, next_muted, mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			muted_q <= 1'b0;
			mode_q  <= MODE_RESET;
		end else begin
			if (send_mode_we) begin
				mode_q <= send_mode;
			end
			if (accept) begin
				level_q <= next_level;
				muted_q <= next_muted;
			end
		end
	end

endmodule

[hdl/lras_queue.sv]
module lras_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= ~wr_ptr_q;
			if (do_rd) rd_ptr_q <= ~rd_ptr_q;
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

[hdl/lras_back.sv]
module lras_back #(
	parameter int LEVEL_BITS = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  logic [LEVEL_BITS+1:0] q_data,
	output logic                  q_pop,
	input  logic                  pop,
	output logic                  empty,
	output lras_pkg::frame_t      frame
);
	import lras_pkg::*;

	localparam int IDX_MAX = (LEVEL_BITS > 2) ? LEVEL_BITS : 2;
	localparam int IDX_W   = $clog2(IDX_MAX + 1);

	logic [LEVEL_BITS-1:0] lv_q;
	logic                  muted_q;
	logic                  mode_q;
	logic                  active_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  out_valid_q;
	frame_t                frame_q;

	logic                  adv;
	logic                  is_last;
	logic [IDX_W-1:0]      last_idx;
	logic [IDX_W-1:0]      shamt;
	logic [LEVEL_BITS-1:0] sel;
	logic [LEVEL_BITS-1:0] pass_v;
	logic [LEVEL_BITS-1:0] atten_v;
	logic [LEVEL_BITS+5:0] pass_ext;
	logic [LEVEL_BITS+5:0] atten_ext;
	logic                  hold_v;

	assign last_idx = (mode_q == MODE_POWERSAVE) ? IDX_W'(LEVEL_BITS) : IDX_W'(2);
	assign is_last  = (idx_q == last_idx);
	assign adv      = active_q & (~out_valid_q | pop);
	assign q_pop    = ~q_empty & (~active_q | (adv & is_last));

	// power-save: walk level bits from the top one down
	assign shamt = IDX_W'(LEVEL_BITS - 1) - idx_q;
	assign sel   = {{(LEVEL_BITS-1){1'b0}}, 1'b1} << shamt;

	always_comb begin
		pass_v  = '0;
		atten_v = '0;
		hold_v  = 1'b0;
		if (!is_last) begin
			if (mode_q == MODE_POWERSAVE) begin
				pass_v  = lv_q & sel;
				atten_v = ~lv_q & sel;
				hold_v  = 1'b1;
			end else begin
				pass_v = lv_q;
				if (idx_q != '0) begin
					atten_v = ~lv_q;
					hold_v  = 1'b1;
				end
			end
		end
	end

	assign pass_ext  = {6'b0, pass_v};
	assign atten_ext = {6'b0, atten_v};

	always_ff @(posedge clk) begin
		if (adv) begin
			frame_q.relay_word <= build_frame(pass_ext[5:0], atten_ext[5:0], muted_q);
			frame_q.hold_after <= hold_v;
			frame_q.last       <= is_last;
		end
		if (q_pop) begin
			lv_q    <= q_data[LEVEL_BITS+1:2];
			muted_q <= q_data[1];
			mode_q  <= q_data[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (adv) begin
				if (is_last) begin
					active_q <= 1'b0;
				end
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	assign empty = ~out_valid_q;
	assign frame = frame_q;

endmodule

[hdl/latching_relay_attenuator_sequencer.sv]
// Latching-relay attenuator sequencer. Requests (set level, set level and
// mute, mute, unmute) are pushed in and turn into a short train of 16-bit
// relay frames popped out the other side. Normal mode gives 3 frames per
// request (pass-only, full pass/attenuate held one pulse time, then all
// pairs off); power-save mode gives LEVEL_BITS+1 frames (one held frame per
// level bit, top bit first, then the off frame). The final frame of each
// request has last set. A mute while already muted, or an unmute while
// unmuted, gives no frames at all. The back end emits one frame per clock
// while pop keeps up, and moves from one request's last frame straight to
// the next request's first; from idle the accepted push is written into
// the job queue, then loaded into the frame sequencer, which builds
// its first frame into the output register. A request thus occupies the
// frame sequencer for its 3 or LEVEL_BITS+1 frames, which sets the
// sustained rate. Level and mute state update when the request is pushed;
// send_mode_we sets the mode each job takes at push; it resets to power-save.
module latching_relay_attenuator_sequencer #(
	parameter int LEVEL_BITS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [5:0]  level,
	input  logic        mute_flag,
	// frame side
	output logic        empty,
	input  logic        pop,
	output logic [15:0] relay_word,
	output logic        hold_after,
	output logic        last,
	// configuration
	input  logic        send_mode_we,
	input  logic        send_mode
);
	import lras_pkg::*;

	localparam int JOB_W = LEVEL_BITS + 2;

	// job word: {level, muted, mode}
	logic             job_push;
	logic [JOB_W-1:0] job_wdata;
	logic [JOB_W-1:0] job_rdata;
	logic             job_pop;
	logic             job_full;
	logic             job_empty;
	frame_t           frame;

	// front: classify requests, track level/mute, queue a job when frames are due
	lras_front #(.LEVEL_BITS(LEVEL_BITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.req_type     (req_type),
		.level        (level),
		.mute_flag    (mute_flag),
		.send_mode_we (send_mode_we),
		.send_mode    (send_mode),
		.q_full       (job_full),
		.q_push       (job_push),
		.q_data       (job_wdata)
	);

	// two-entry job queue decouples request intake from frame output
	lras_queue #(.WIDTH(JOB_W)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (job_wdata),
		.rd_en   (job_pop),
		.rd_data (job_rdata),
		.full    (job_full),
		.empty   (job_empty)
	);

	// back: frame sequencer with registered output
	lras_back #(.LEVEL_BITS(LEVEL_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (job_empty),
		.q_data  (job_rdata),
		.q_pop   (job_pop),
		.pop     (pop),
		.empty   (empty),
		.frame   (frame)
	);

	// intake stalls only when the job queue is full
	assign full       = job_full;
	assign relay_word = frame.relay_word;
	assign hold_after = frame.hold_after;
	assign last       = frame.last;

endmodule
